@@ design/blru_pkg.sv @@
// ----------------------------------------------------------------------------
// blru_pkg: shared types and constants for the byte budget LRU cache
// Result kinds, sequencer states and the per-cell control word.
// ----------------------------------------------------------------------------
package blru_pkg;

   localparam int DEF_ENTRIES  = 16;
   localparam int DEF_KEY_BITS = 16;

   localparam int KEY_PORT_W  = 16;
   localparam int SIZE_W      = 32;
   localparam int REQ_DATA_W  = KEY_PORT_W + SIZE_W;
   localparam int RSP_DATA_W  = KEY_PORT_W + SIZE_W + SIZE_W;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [31:0] BUDGET_RESET = 32'd65536;

   // register index, taken from paddr[2]
   localparam logic REG_BUDGET = 1'b0;

   typedef enum logic [1:0] {
      KIND_EVICT   = 2'd0,
      KIND_HIT     = 2'd1,
      KIND_INSERT  = 2'd2,
      KIND_TOO_BIG = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_EVICT
   } state_type;

   // load: take the neighbor's entry; clear: drop this entry
   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctrl_type;

endpackage

@@ design/blru_cell.sv @@
// ----------------------------------------------------------------------------
// blru_cell: one position of the recency chain
// Holds one entry; position 0 is most recent. Shifts in from its neighbor,
// drops its entry, and compares its key against the lookup key.
// ----------------------------------------------------------------------------
module blru_cell #(
   parameter int KW = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  blru_pkg::cell_ctrl_type ctrl,
   input  logic                  prev_valid,
   input  logic [KW-1:0]         prev_key,
   input  logic [31:0]           prev_size,
   input  logic [KW-1:0]         look_key,
   output logic                  valid,
   output logic [KW-1:0]         key,
   output logic [31:0]           size,
   output logic                  match
);
   import blru_pkg::*;

   logic          valid_ff;
   logic [KW-1:0] key_ff;
   logic [31:0]   size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= prev_valid;
      end else if (ctrl.clear) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         key_ff  <= prev_key;
         size_ff <= prev_size;
      end
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign size  = size_ff;
   assign match = valid_ff && (key_ff == look_key);

endmodule

@@ design/byte_budget_lru_cache.sv @@
// ----------------------------------------------------------------------------
// byte_budget_lru_cache: size-aware LRU cache with a byte budget
// Request words carry a key and an item size. Each request yields zero or
// more eviction words followed by one final word marked with tlast.
// ----------------------------------------------------------------------------
// Usage:
//  req_*  : request words {item_size, key_id}; taken one at a time.
//  rsp_*  : result words {bytes_used, result_size, result_key}, kind on
//           tuser, tlast on the final word of a request.
//  csr_*  : APB register port, byte_budget at address 0.
// Steps: a request passes the lookup and decide states; a hit or a too-large
// miss is written to the output register from decide, while an inserting
// miss goes on to the evict state for each eviction word and the insert word.
// Entries live in a chain of cells ordered by recency; the sequencer does
// one chain update (shift, drop or insert) and emits one word per cycle.
// The output register frees the request side: a new request is taken while
// the last result word still waits. When rsp_tready is low the sequencer
// holds its step until the output register drains.
// Reset empties the chain, zeroes bytes_used and sets the budget to 65536.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache #(
   parameter int ENTRIES  = blru_pkg::DEF_ENTRIES,
   parameter int KEY_BITS = blru_pkg::DEF_KEY_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] key_id, [47:16] item_size
   input  logic [blru_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] result_key, [47:16] result_size, [79:48] bytes_used
   output logic [blru_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [1:0] kind
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [blru_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [blru_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [blru_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import blru_pkg::*;

   localparam int KW = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
   localparam int CW = $clog2(ENTRIES + 1);

   state_type     state_ff, state_in;
   logic [KW-1:0] key_ff;
   logic [31:0]   size_ff;
   logic [31:0]   budget_ff;
   logic [31:0]   total_ff, total_in;
   logic [CW-1:0] count_ff, count_in;
   logic [ENTRIES-1:0] match_ff;

   logic          rsp_valid_ff;
   kind_type      rsp_kind_ff;
   logic [15:0]   rsp_key_ff;
   logic [31:0]   rsp_size_ff;
   logic [31:0]   rsp_used_ff;
   logic          rsp_last_ff;

   logic          emit;
   kind_type      e_kind;
   logic [15:0]   e_key;
   logic [31:0]   e_size;
   logic [31:0]   e_used;
   logic          e_last;

   logic               cell_valid [ENTRIES];
   logic [KW-1:0]      cell_key   [ENTRIES];
   logic [31:0]        cell_size  [ENTRIES];
   logic [ENTRIES-1:0] cell_match;
   cell_ctrl_type      cell_ctrl  [ENTRIES];
   logic [ENTRIES-1:0] load_vec, clear_vec;

   logic [ENTRIES-1:0] upto_hit, tail;
   logic [KW-1:0]      hit_key, tail_key, head_key;
   logic [31:0]        hit_size, tail_size, head_size;
   logic               hit, head_hit, out_free, need_evict, csr_write;
   logic [32:0]        sum_wide;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_BUDGET) ? budget_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
      end else if (csr_write && csr_paddr[2] == REG_BUDGET) begin
         budget_ff <= csr_pwdata;
      end
   end

   // ---------------- cell chain ----------------
   assign head_key  = head_hit ? hit_key : key_ff;
   assign head_size = head_hit ? hit_size : size_ff;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      assign cell_ctrl[g] = '{load: load_vec[g], clear: clear_vec[g]};
      if (g == 0) begin : g_head
         blru_cell #(.KW(KW)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl[g]),
            .prev_valid (1'b1),
            .prev_key   (head_key),
            .prev_size  (head_size),
            .look_key   (key_ff),
            .valid      (cell_valid[g]),
            .key        (cell_key[g]),
            .size       (cell_size[g]),
            .match      (cell_match[g])
         );
      end else begin : g_body
         blru_cell #(.KW(KW)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl[g]),
            .prev_valid (cell_valid[g-1]),
            .prev_key   (cell_key[g-1]),
            .prev_size  (cell_size[g-1]),
            .look_key   (key_ff),
            .valid      (cell_valid[g]),
            .key        (cell_key[g]),
            .size       (cell_size[g]),
            .match      (cell_match[g])
         );
      end
   end

   // hit entry, cells from the head down to the hit, and the least recent entry
   always_comb begin
      logic acc;
      hit_key   = '0;
      hit_size  = '0;
      tail_key  = '0;
      tail_size = '0;
      acc       = 1'b0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         acc         = acc | match_ff[i];
         upto_hit[i] = acc;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (i == ENTRIES - 1) begin
            tail[i] = cell_valid[i];
         end else begin
            tail[i] = cell_valid[i] && !cell_valid[i+1];
         end
         hit_key   = hit_key   | (cell_key[i]  & {KW{match_ff[i]}});
         hit_size  = hit_size  | (cell_size[i] & {32{match_ff[i]}});
         tail_key  = tail_key  | (cell_key[i]  & {KW{tail[i]}});
         tail_size = tail_size | (cell_size[i] & {32{tail[i]}});
      end
   end

   assign hit        = |match_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign sum_wide   = {1'b0, total_ff} + {1'b0, size_ff};
   assign need_evict = (count_ff != '0) &&
                       ((sum_wide > {1'b0, budget_ff}) || (count_ff == CW'(ENTRIES)));

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= cell_match;
      if (req_tvalid && req_tready) begin
         key_ff  <= req_tdata[KW-1:0];
         size_ff <= req_tdata[KEY_PORT_W +: SIZE_W];
      end
   end

   always_comb begin
      state_in   = state_ff;
      total_in   = total_ff;
      count_in   = count_ff;
      req_tready = 1'b0;
      emit       = 1'b0;
      e_kind     = KIND_INSERT;
      e_key      = 16'(key_ff);
      e_size     = size_ff;
      e_used     = total_ff;
      e_last     = 1'b1;
      load_vec   = '0;
      clear_vec  = '0;
      head_hit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (hit) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_kind   = KIND_HIT;
                  e_size   = hit_size;
                  head_hit = 1'b1;
                  load_vec = upto_hit;
                  state_in = ST_IDLE;
               end
            end else if (size_ff > budget_ff) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_kind   = KIND_TOO_BIG;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            if (out_free) begin
               emit = 1'b1;
               if (need_evict) begin
                  e_kind    = KIND_EVICT;
                  e_key     = 16'(tail_key);
                  e_size    = tail_size;
                  e_last    = 1'b0;
                  e_used    = total_ff - tail_size;
                  clear_vec = tail;
                  total_in  = total_ff - tail_size;
                  count_in  = count_ff - CW'(1);
               end else begin
                  e_kind   = KIND_INSERT;
                  e_used   = sum_wide[31:0];
                  load_vec = '1;
                  total_in = sum_wide[31:0];
                  count_in = count_ff + CW'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff <= e_kind;
         rsp_key_ff  <= e_key;
         rsp_size_ff <= e_size;
         rsp_used_ff <= e_used;
         rsp_last_ff <= e_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_used_ff, rsp_size_ff, rsp_key_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the byte budget LRU cache
// Drives request words and APB writes and reads of the budget register, keeps its own
// recency-ordered copy of the cache and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_top;
   import blru_pkg::*;

   localparam int TB_ENTRIES    = blru_pkg::DEF_ENTRIES;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 40;
   localparam int PRINT_LIMIT   = 40;

   localparam logic [CSR_ADDR_W-1:0] ADDR_BUDGET = {REG_BUDGET, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

   typedef struct {
      logic [15:0] key;
      logic [31:0] size;
   } cache_line_type;

   typedef struct {
      kind_type    kind;
      logic [15:0] key;
      logic [31:0] size;
      logic [31:0] bytes_used;
      logic        last;
   } cache_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // shadow cache: index 0 is the most recent line
   cache_line_type lru_order[$];
   logic [31:0] budget_model = BUDGET_RESET;
   logic [31:0] bytes_model = '0;
   cache_word_type expected_words[$];

   int  error_count = 0;
   int  quiet_cycles = 0;
   bit  req_idle_on = 1'b1;
   bit  rsp_idle_on = 1'b1;
   int  rsp_hold_req = 0;
   int  rsp_hold_left = 0;
   logic [15:0] key_base = '0;

   byte_budget_lru_cache dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("%0t: %s mismatch: got %0h, want %0h", $time, what, got, want);
   endtask

   function automatic void push_word(kind_type kind, logic [15:0] key,
                                     logic [31:0] size, logic last);
      cache_word_type w;
      w.kind       = kind;
      w.key        = key;
      w.size       = size;
      w.bytes_used = bytes_model;
      w.last       = last;
      expected_words.push_back(w);
   endfunction

   // one request against the shadow cache; queues every word it should cause
   function automatic void model_cache_access(logic [15:0] key, logic [31:0] size);
      int hit_at;
      cache_line_type line;
      hit_at = -1;
      foreach (lru_order[i])
         if (lru_order[i].key == key) begin
            hit_at = i;
            break;
         end
      if (hit_at >= 0) begin
         line = lru_order[hit_at];
         lru_order.delete(hit_at);
         lru_order.push_front(line);
         push_word(KIND_HIT, key, line.size, 1'b1);
      end else if (size > budget_model) begin
         push_word(KIND_TOO_BIG, key, size, 1'b1);
      end else begin
         // sum checked in 33 bits so it cannot wrap
         while (lru_order.size() > 0 &&
                (({1'b0, bytes_model} + {1'b0, size} > {1'b0, budget_model}) ||
                 lru_order.size() >= TB_ENTRIES)) begin
            line = lru_order[lru_order.size() - 1];
            lru_order.delete(lru_order.size() - 1);
            bytes_model -= line.size;
            push_word(KIND_EVICT, line.key, line.size, 1'b0);
         end
         line.key  = key;
         line.size = size;
         lru_order.push_front(line);
         bytes_model += size;
         push_word(KIND_INSERT, key, size, 1'b1);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!req_idle_on || r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   function automatic logic [15:0] pick_key();
      if ($urandom_range(0, 99) < 15)
         return 16'($urandom());
      return key_base + 16'($urandom_range(0, 23));
   endfunction

   function automatic logic [31:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return '0;
      else if (r < 60)
         return $urandom_range(0, budget_model >> 3);
      else if (r < 80)
         return $urandom_range(0, budget_model >> 1);
      else if (r < 87)
         return budget_model;
      else if (r < 93)
         return budget_model + 32'd1;
      else
         return $urandom();
   endfunction

   // drive one request word and wait for it to be taken
   task automatic send_request(input logic [15:0] key, input logic [31:0] size);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {size, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model_cache_access(key, size);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = addr;
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      if (wr && addr == ADDR_BUDGET)
         budget_model = wdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic write_budget(input logic [31:0] value);
      logic [31:0] rd;
      wait_idle();
      csr_access(1'b1, ADDR_BUDGET, value, rd);
      csr_access(1'b0, ADDR_BUDGET, '0, rd);
      if (rd !== budget_model)
         report_mismatch("budget readback", rd, budget_model);
   endtask

   task automatic test_hit_and_miss();
      send_request(16'h0000, 32'd0);          // zero-size insert
      send_request(16'hFFFF, 32'd100);
      send_request(16'h0000, 32'hFFFF_FFFF);  // hit, size ignored
      send_request(16'h0007, 32'd65537);      // one over budget
      send_request(16'h0008, 32'hFFFF_FFFF);
      send_request(16'h0009, 32'd65536);      // exactly the budget
      send_request(16'h0000, 32'd5);
   endtask

   task automatic test_table_full();
      write_budget(32'd1000);
      // first insert also drains what the old budget allowed
      for (int i = 0; i < TB_ENTRIES; i++)
         send_request(16'h0100 + 16'(i), 32'd10);
      send_request(16'h0100, 32'd3);          // oldest line becomes newest
      send_request(16'h0200, 32'd10);         // full table evicts one
      send_request(16'h0300, 32'd1000);       // evicts every line
   endtask

   task automatic test_budget_register();
      logic [31:0] rd;
      write_budget(32'd40);
      send_request(16'h0401, 32'd30);
      write_budget(32'd0);
      send_request(16'h0402, 32'd0);
      send_request(16'h0403, 32'd1);
      write_budget(32'hFFFF_FFFF);
      send_request(16'h0404, 32'hFFFF_FFF0);
      send_request(16'h0405, 32'h0000_0020);  // sum would wrap
      wait_idle();
      // unmapped register: write must leave the budget alone
      csr_access(1'b1, ADDR_UNUSED, 32'h0000_0123, rd);
      csr_access(1'b0, ADDR_BUDGET, '0, rd);
      if (rd !== budget_model)
         report_mismatch("budget after unmapped write", rd, budget_model);
   endtask

   task automatic test_backpressure();
      write_budget(32'd65536);
      key_base    = 16'($urandom());
      req_idle_on = 1'b0;
      rsp_hold_req = 300;
      for (int i = 0; i < 24; i++)
         send_request(pick_key(), pick_size());
      wait_idle();
      req_idle_on = 1'b1;
   endtask

   task automatic test_random();
      logic [31:0] budgets[4];
      budgets[0] = 32'd65536;
      budgets[1] = $urandom_range(200, 5000);
      budgets[2] = $urandom();
      budgets[3] = 32'hFFFF_FFFF;
      for (int p = 0; p < 4; p++) begin
         write_budget(budgets[p]);
         key_base = 16'($urandom());
         for (int i = 0; i < 26; i++) begin
            if (i % 16 == 0) begin
               req_idle_on = ($urandom_range(0, 3) != 0);
               rsp_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_request(pick_key(), pick_size());
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      int r;
      if (rsp_hold_left > 0) begin
         rsp_tready = 1'b0;
         rsp_hold_left--;
      end else if (rsp_hold_req > 0) begin
         rsp_tready    = 1'b0;
         rsp_hold_left = rsp_hold_req - 1;
         rsp_hold_req  = 0;
      end else if (!rsp_idle_on) begin
         rsp_tready = 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            rsp_tready = 1'b1;
         end else if (r < 95) begin
            rsp_tready    = 1'b0;
            rsp_hold_left = $urandom_range(0, 2);
         end else begin
            rsp_tready    = 1'b0;
            rsp_hold_left = $urandom_range(8, 40);
         end
      end
   end

   always @(posedge clock) begin
      cache_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, key", 32'(rsp_tdata[15:0]), '0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("kind", 32'(rsp_tuser), 32'(want.kind));
            if (rsp_tdata[15:0] !== want.key)
               report_mismatch("result_key", 32'(rsp_tdata[15:0]), 32'(want.key));
            if (rsp_tdata[47:16] !== want.size)
               report_mismatch("result_size", rsp_tdata[47:16], want.size);
            if (rsp_tdata[79:48] !== want.bytes_used)
               report_mismatch("bytes_used", rsp_tdata[79:48], want.bytes_used);
            if (rsp_tlast !== want.last)
               report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      repeat (7) @(negedge clock);
      reset = 1'b0;
      test_hit_and_miss();
      test_table_full();
      test_budget_register();
      test_backpressure();
      test_random();
      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0 && expected_words.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

@@ files.f @@
design/blru_pkg.sv
design/blru_cell.sv
design/byte_budget_lru_cache.sv
sim/tb_top.sv
